// ----- rtl/core/keyed_recency_order_list_defines.svh -----
// Assertion helpers; i_clk and i_rst_n are taken from the enclosing module.
`ifndef KEYED_RECENCY_ORDER_LIST_DEFINES_SVH
`define KEYED_RECENCY_ORDER_LIST_DEFINES_SVH

// Same-cycle implication.
`define KROL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define KROL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/krol_pkg.sv -----
package krol_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int KEY_W    = 16;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_POP_HEAD = 3'd3,
        REQ_POP_TAIL = 3'd4,
        REQ_TO_HEAD  = 3'd5,
        REQ_TO_TAIL  = 3'd6,
        REQ_CLEAR    = 3'd7
    } t_req_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status_e;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic   cmp;    // latch key compare result
        logic   apply;  // commit the list update
        t_req_e op;
    } t_cell_ctl;

endpackage

// ----- rtl/core/krol_req_if.sv -----
interface krol_req_if;
    logic                        valid;
    logic                        ready;
    logic [krol_pkg::REQ_W-1:0]  req_type;
    logic [krol_pkg::KEY_W-1:0]  key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ----- rtl/core/krol_rsp_if.sv -----
interface krol_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [krol_pkg::STATUS_W-1:0]  status;
    logic [krol_pkg::COUNT_W-1:0]   count;
    logic [krol_pkg::KEY_W-1:0]     head_key;
    logic [krol_pkg::KEY_W-1:0]     tail_key;

    modport source (output valid, output status, output count, output head_key,
                    output tail_key, input ready);
    modport sink   (input valid, input status, input count, input head_key,
                    input tail_key, output ready);
endinterface

// ----- rtl/core/krol_cell.sv -----
module krol_cell #(
    parameter int IDX      = 0,
    parameter int CW       = 5,
    parameter int KEY_BITS = krol_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  krol_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_cnt,
    input  logic [KEY_BITS-1:0] i_req_key,
    input  logic [KEY_BITS-1:0] i_left,
    input  logic [KEY_BITS-1:0] i_right,
    input  logic                i_incl,   // at or past the first match
    input  logic                i_excl,   // strictly past the first match
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_match
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_match;
    logic                w_is_last;

    assign w_is_last = (IDX_C == i_cnt - 1'b1);

    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            krol_pkg::REQ_INS_HEAD: begin
                n_key = (IDX == 0) ? i_req_key : i_left;
            end
            krol_pkg::REQ_INS_TAIL: begin
                if (IDX_C == i_cnt) n_key = i_req_key;
            end
            krol_pkg::REQ_REMOVE: begin
                if (i_incl) n_key = i_right;
            end
            krol_pkg::REQ_POP_HEAD: begin
                n_key = i_right;
            end
            krol_pkg::REQ_TO_HEAD: begin
                if (IDX == 0) n_key = i_req_key;
                else if (!i_excl) n_key = i_left;
            end
            krol_pkg::REQ_TO_TAIL: begin
                if (w_is_last) n_key = i_req_key;
                else if (i_incl) n_key = i_right;
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) r_key <= n_key;
        if (i_ctl.cmp)   r_match <= (IDX_C < i_cnt) && (r_key == i_req_key);
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

// ----- rtl/core/keyed_recency_order_list.sv -----
// From request transaction to response valid: key compare in every cell (S_MATCH),
// list update (S_APPLY), head/tail readout into the output register (S_REPORT).
// A new request is taken only in S_IDLE, once the previous response has been
// registered; an output stall holds the sequence in S_REPORT.
// Reset: i_rst_n synchronous active low; empties the list and drops any
// pending response. Cell keys are not reset.
`include "keyed_recency_order_list_defines.svh"

module keyed_recency_order_list #(
    parameter int CAPACITY = krol_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = krol_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    krol_req_if.sink   i_req,
    krol_rsp_if.source o_rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int LVLS = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_APPLY  = 4'b0100,
        S_REPORT = 4'b1000
    } t_state_e;

    t_state_e              r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    krol_pkg::t_req_e      r_op;
    logic [KEY_BITS-1:0]   r_req_key;
    krol_pkg::t_status_e   r_status, n_status;

    logic                                r_rsp_valid;
    logic [krol_pkg::STATUS_W-1:0]       r_rsp_status;
    logic [krol_pkg::COUNT_W-1:0]        r_rsp_count;
    logic [krol_pkg::KEY_W-1:0]          r_rsp_head;
    logic [krol_pkg::KEY_W-1:0]          r_rsp_tail;

    logic [KEY_BITS-1:0]   w_keys [CAPACITY];
    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY-1:0]   w_incl;
    logic [CAPACITY-1:0]   w_excl;
    logic                  w_found;
    logic                  w_ok;
    logic                  w_accept;
    logic                  w_out_free;
    krol_pkg::t_cell_ctl   w_ctl;
    logic [31:0]           w_key32;
    logic [31:0]           w_cnt32;
    logic [31:0]           w_head32;
    logic [31:0]           w_tail32;
    logic [CW-1:0]         w_last;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_key32    = 32'(i_req.key);

    // Inclusive prefix OR of match bits: everything at or after the first hit.
    always_comb begin
        w_incl = w_match;
        for (int l = 0; l < LVLS; l++) begin
            w_incl = w_incl | (w_incl << (1 << l));
        end
    end
    assign w_excl  = w_incl << 1;
    assign w_found = w_incl[CAPACITY-1];

    always_comb begin
        n_status = krol_pkg::ST_OK;
        n_cnt    = r_cnt;
        case (r_op)
            krol_pkg::REQ_INS_HEAD, krol_pkg::REQ_INS_TAIL: begin
                if (r_cnt >= CAP_C) n_status = krol_pkg::ST_FULL;
                else n_cnt = r_cnt + 1'b1;
            end
            krol_pkg::REQ_REMOVE, krol_pkg::REQ_TO_HEAD, krol_pkg::REQ_TO_TAIL: begin
                if (r_cnt == '0) n_status = krol_pkg::ST_EMPTY;
                else if (!w_found) n_status = krol_pkg::ST_NOT_FOUND;
                else if (r_op == krol_pkg::REQ_REMOVE) n_cnt = r_cnt - 1'b1;
            end
            krol_pkg::REQ_POP_HEAD, krol_pkg::REQ_POP_TAIL: begin
                if (r_cnt == '0) n_status = krol_pkg::ST_EMPTY;
                else n_cnt = r_cnt - 1'b1;
            end
            krol_pkg::REQ_CLEAR: begin
                n_cnt = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    assign w_ok = (n_status == krol_pkg::ST_OK);

    always_comb begin
        w_ctl.cmp   = (r_state == S_MATCH);
        w_ctl.apply = (r_state == S_APPLY) && w_ok;
        w_ctl.op    = r_op;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MATCH;
            S_MATCH:  n_state = S_APPLY;
            S_APPLY:  n_state = S_REPORT;
            S_REPORT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY) r_cnt <= n_cnt;
            if (r_state == S_REPORT && w_out_free) r_rsp_valid <= 1'b1;
            else if (o_rsp.ready) r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= krol_pkg::t_req_e'(i_req.req_type);
            r_req_key <= w_key32[KEY_BITS-1:0];
        end
        if (r_state == S_APPLY) r_status <= n_status;
        if (r_state == S_REPORT && w_out_free) begin
            r_rsp_status <= r_status;
            r_rsp_count  <= w_cnt32[krol_pkg::COUNT_W-1:0];
            r_rsp_head   <= (r_cnt == '0) ? '0 : w_head32[krol_pkg::KEY_W-1:0];
            r_rsp_tail   <= (r_cnt == '0) ? '0 : w_tail32[krol_pkg::KEY_W-1:0];
        end
    end

    assign w_last   = r_cnt - 1'b1;
    assign w_cnt32  = 32'(r_cnt);
    assign w_head32 = 32'(w_keys[0]);
    assign w_tail32 = 32'(w_keys[w_last[IW-1:0]]);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_left;
        logic [KEY_BITS-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_keys[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_keys[g+1];
        end

        krol_cell #(
            .IDX      (g),
            .CW       (CW),
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_cnt     (r_cnt),
            .i_req_key (r_req_key),
            .i_left    (w_left),
            .i_right   (w_right),
            .i_incl    (w_incl[g]),
            .i_excl    (w_excl[g]),
            .o_key     (w_keys[g]),
            .o_match   (w_match[g])
        );
    end

    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.status   = r_rsp_status;
    assign o_rsp.count    = r_rsp_count;
    assign o_rsp.head_key = r_rsp_head;
    assign o_rsp.tail_key = r_rsp_tail;

    `KROL_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CAP_C)
    `KROL_ASSERT_NXT(a_accept_seq, w_accept, r_state == S_MATCH)
    `KROL_ASSERT_NXT(a_full_keeps, (r_state == S_APPLY) && (n_status == krol_pkg::ST_FULL),
        r_cnt == $past(r_cnt))
    `KROL_ASSERT_IMP(a_empty_zero, r_rsp_valid && (r_rsp_count == '0) && (CAPACITY < 32),
        (r_rsp_head == '0) && (r_rsp_tail == '0))

endmodule

// ----- tb/recency_list_monitor.sv -----
`timescale 1ns / 1ps

module recency_list_monitor #(
    parameter int CAPACITY = krol_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = krol_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [krol_pkg::REQ_W-1:0]    i_req_type,
    input  logic [krol_pkg::KEY_W-1:0]    i_req_key,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [krol_pkg::STATUS_W-1:0] i_rsp_status,
    input  logic [krol_pkg::COUNT_W-1:0]  i_rsp_count,
    input  logic [krol_pkg::KEY_W-1:0]    i_rsp_head_key,
    input  logic [krol_pkg::KEY_W-1:0]    i_rsp_tail_key,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int KEY_W   = krol_pkg::KEY_W;
    localparam int COUNT_W = krol_pkg::COUNT_W;
    // keys are cut to KEY_BITS before they enter the list
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? '1 : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    typedef struct packed {
        krol_pkg::t_status_e  status;
        logic [COUNT_W-1:0]   count;
        logic [KEY_W-1:0]     head_key;
        logic [KEY_W-1:0]     tail_key;
    } t_list_view;

    // Shadow of the list contents, head at index 0.
    logic [KEY_W-1:0] order_q[$];
    t_list_view       expected_q[$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one request to the shadow list and returns the view afterwards.
    task automatic apply_request(input krol_pkg::t_req_e op, input logic [KEY_W-1:0] key,
                                 output t_list_view view);
        int                  pos;
        krol_pkg::t_status_e st;
        st  = krol_pkg::ST_OK;
        pos = -1;
        case (op)
            krol_pkg::REQ_INS_HEAD, krol_pkg::REQ_INS_TAIL: begin
                if (order_q.size() >= CAPACITY)
                    st = krol_pkg::ST_FULL;
                else if (op == krol_pkg::REQ_INS_HEAD)
                    order_q.push_front(key);
                else
                    order_q.push_back(key);
            end
            krol_pkg::REQ_REMOVE, krol_pkg::REQ_TO_HEAD, krol_pkg::REQ_TO_TAIL: begin
                if (order_q.size() == 0) begin
                    st = krol_pkg::ST_EMPTY;
                end else begin
                    // first match from the head wins when keys repeat
                    for (int i = 0; i < order_q.size() && pos < 0; i++)
                        if (order_q[i] == key)
                            pos = i;
                    if (pos < 0) begin
                        st = krol_pkg::ST_NOT_FOUND;
                    end else begin
                        order_q.delete(pos);
                        if (op == krol_pkg::REQ_TO_HEAD)
                            order_q.push_front(key);
                        else if (op == krol_pkg::REQ_TO_TAIL)
                            order_q.push_back(key);
                    end
                end
            end
            krol_pkg::REQ_POP_HEAD: begin
                if (order_q.size() == 0)
                    st = krol_pkg::ST_EMPTY;
                else
                    void'(order_q.pop_front());
            end
            krol_pkg::REQ_POP_TAIL: begin
                if (order_q.size() == 0)
                    st = krol_pkg::ST_EMPTY;
                else
                    void'(order_q.pop_back());
            end
            default: begin
                order_q.delete();
            end
        endcase
        view.status = st;
        view.count  = COUNT_W'(order_q.size());
        if (order_q.size() == 0) begin
            view.head_key = '0;
            view.tail_key = '0;
        end else begin
            view.head_key = order_q[0];
            view.tail_key = order_q[order_q.size() - 1];
        end
    endtask

    always @(posedge i_clk) begin
        t_list_view view;
        if (i_rst_n) begin
            // response side first: a response never belongs to a request of the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("response with none outstanding", 32'(i_rsp_status), 0);
                end else begin
                    view = expected_q.pop_front();
                    if (i_rsp_status !== view.status)
                        report_mismatch("status", 32'(i_rsp_status), 32'(view.status));
                    if (i_rsp_count !== view.count)
                        report_mismatch("count", 32'(i_rsp_count), 32'(view.count));
                    if (i_rsp_head_key !== view.head_key)
                        report_mismatch("head_key", 32'(i_rsp_head_key), 32'(view.head_key));
                    if (i_rsp_tail_key !== view.tail_key)
                        report_mismatch("tail_key", 32'(i_rsp_tail_key), 32'(view.tail_key));
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(krol_pkg::t_req_e'(i_req_type), i_req_key & KEY_MASK, view);
                expected_q.push_back(view);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int KEY_W          = krol_pkg::KEY_W;
    localparam int DIRECTED_N     = 24;
    localparam int RANDOM_N       = 490;
    localparam int CALM_TAIL      = 80;
    localparam int POOL_N         = 6;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} t_mix_e;

    logic i_clk;
    logic i_rst_n;

    krol_req_if req_if();
    krol_rsp_if rsp_if();

    int fail_count;
    int pending_cnt;
    int items_sent = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int quiet_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_N];

    keyed_recency_order_list #(
        .CAPACITY(krol_pkg::CAPACITY_DEF),
        .KEY_BITS(krol_pkg::KEY_BITS_DEF)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    recency_list_monitor #(
        .CAPACITY(krol_pkg::CAPACITY_DEF),
        .KEY_BITS(krol_pkg::KEY_BITS_DEF)
    ) list_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_if.valid),
        .i_req_ready   (req_if.ready),
        .i_req_type    (req_if.req_type),
        .i_req_key     (req_if.key),
        .i_rsp_valid   (rsp_if.valid),
        .i_rsp_ready   (rsp_if.ready),
        .i_rsp_status  (rsp_if.status),
        .i_rsp_count   (rsp_if.count),
        .i_rsp_head_key(rsp_if.head_key),
        .i_rsp_tail_key(rsp_if.tail_key),
        .o_fail_count  (fail_count),
        .o_pending     (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Ends the run if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Response backpressure in random bursts.
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input krol_pkg::t_req_e op, input logic [KEY_W-1:0] key);
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.key      <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Holds off new requests until every outstanding response has arrived.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 25;
            default: return 40;
        endcase
    endfunction

    function automatic krol_pkg::t_req_e pick_insert();
        return krol_pkg::t_req_e'($urandom_range(krol_pkg::REQ_INS_HEAD,
                                                 krol_pkg::REQ_INS_TAIL));
    endfunction

    function automatic krol_pkg::t_req_e pick_lookup();
        case ($urandom_range(0, 2))
            0:       return krol_pkg::REQ_REMOVE;
            1:       return krol_pkg::REQ_TO_HEAD;
            default: return krol_pkg::REQ_TO_TAIL;
        endcase
    endfunction

    function automatic krol_pkg::t_req_e pick_pop();
        return krol_pkg::t_req_e'($urandom_range(krol_pkg::REQ_POP_HEAD,
                                                 krol_pkg::REQ_POP_TAIL));
    endfunction

    function automatic krol_pkg::t_req_e pick_op(t_mix_e mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return krol_pkg::REQ_CLEAR;
        case (mix)
            MIX_FILL: begin
                if (roll < 60) return pick_insert();
                if (roll < 85) return pick_lookup();
                return pick_pop();
            end
            MIX_DRAIN: begin
                if (roll < 25) return pick_insert();
                if (roll < 55) return pick_lookup();
                return pick_pop();
            end
            default: begin
                return krol_pkg::t_req_e'($urandom_range(krol_pkg::REQ_INS_HEAD,
                                                         krol_pkg::REQ_TO_TAIL));
            end
        endcase
    endfunction

    // Mostly keys from a small pool so lookups hit and duplicates pile up.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, POOL_N - 1)];
        return KEY_W'($urandom_range(0, 16'hFFFF));
    endfunction

    initial begin
        int     phase;
        bit     calm;
        t_mix_e mix;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = krol_pkg::REQ_CLEAR;
        req_if.key      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every lookup kind on an empty list
        send_request(krol_pkg::REQ_POP_HEAD, 16'h0000);
        send_request(krol_pkg::REQ_POP_TAIL, 16'hFFFF);
        send_request(krol_pkg::REQ_REMOVE,   16'h0000);
        send_request(krol_pkg::REQ_TO_HEAD,  16'hFFFF);
        send_request(krol_pkg::REQ_TO_TAIL,  16'h0000);
        send_request(krol_pkg::REQ_INS_HEAD, 16'hFFFF);
        send_request(krol_pkg::REQ_INS_TAIL, 16'h0000);
        send_request(krol_pkg::REQ_INS_HEAD, 16'h5AA5);
        send_request(krol_pkg::REQ_INS_TAIL, 16'hA55A);
        send_request(krol_pkg::REQ_REMOVE,   16'h1234);
        // tail moved to head, then back
        send_request(krol_pkg::REQ_TO_HEAD,  16'hA55A);
        send_request(krol_pkg::REQ_TO_TAIL,  16'hA55A);
        // already at the target end
        send_request(krol_pkg::REQ_TO_HEAD,  16'h5AA5);
        send_request(krol_pkg::REQ_TO_TAIL,  16'hA55A);
        // duplicate key: remove takes the one nearest the head
        send_request(krol_pkg::REQ_INS_TAIL, 16'hFFFF);
        send_request(krol_pkg::REQ_REMOVE,   16'hFFFF);
        send_request(krol_pkg::REQ_TO_TAIL,  16'h0000);
        send_request(krol_pkg::REQ_POP_HEAD, 16'hFFFF);
        send_request(krol_pkg::REQ_POP_TAIL, 16'h0000);
        send_request(krol_pkg::REQ_TO_HEAD,  16'h7777);
        send_request(krol_pkg::REQ_CLEAR,    16'hFFFF);
        send_request(krol_pkg::REQ_CLEAR,    16'h0000);
        send_request(krol_pkg::REQ_INS_HEAD, 16'h0001);
        send_request(krol_pkg::REQ_POP_TAIL, 16'h8000);
        drain_responses();

        phase = 0;
        while (items_sent < DIRECTED_N + RANDOM_N) begin
            calm      = (items_sent + CALM_TAIL >= DIRECTED_N + RANDOM_N);
            mix       = t_mix_e'(phase % 3);
            gap_pct   = calm ? 0 : pick_pct();
            stall_pct = calm ? 0 : pick_pct();
            foreach (key_pool[k])
                key_pool[k] = KEY_W'($urandom_range(0, 16'hFFFF));
            // a run of inserts past capacity reaches the full case
            if (mix == MIX_FILL)
                repeat (krol_pkg::CAPACITY_DEF + 2) send_request(pick_insert(), pick_key());
            repeat ($urandom_range(30, 60)) send_request(pick_op(mix), pick_key());
            if (phase == 4)
                drain_responses();
            phase++;
        end

        drain_responses();
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/krol_pkg.sv
rtl/core/krol_req_if.sv
rtl/core/krol_rsp_if.sv
rtl/core/krol_cell.sv
rtl/core/keyed_recency_order_list.sv
tb/recency_list_monitor.sv
tb/tb_top.sv
